// ===== rtl/gnmd_pkg.sv =====
// gnmd_pkg: sizes, cell codes, register map and shared types of the grid
// neighbor mark detector. No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package gnmd_pkg;

  // Grid limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_COLS);      // line store address, column counter
  localparam int CCNT_W = $clog2(MAX_COLS + 1);  // a column count up to MAX_COLS
  localparam int ROW_W  = $clog2(MAX_ROWS + 3);  // row counter, stops at MAX_ROWS + 2
  localparam int CFG_W  = 11;                    // size registers
  localparam int HIT_W  = 10;                    // reported row / column
  localparam int VALUE_W = 4;                    // input digit
  localparam int CODE_W = 2;                     // cell code
  localparam int COLV_W = 3 * CODE_W;            // one window column: upper, middle, lower

  // Compare widths wide enough for both the registers and the limits
  localparam int ROW_CMP_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
  localparam int COL_CMP_W = ((CCNT_W > CFG_W) ? CCNT_W : CFG_W) + 1;

  // Stream and register port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;
  localparam int REG_SEL_BIT = 2;

  // Register indexes (paddr bit REG_SEL_BIT)
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // Reset values of the size registers
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 11'd1024;

  // Cell codes
  localparam logic [CODE_W-1:0] CODE_OTHER = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ONE   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_TWO   = 2'd2;

  // Input digits that map to a code of their own
  localparam logic [VALUE_W-1:0] DIGIT_ONE = 4'd1;
  localparam logic [VALUE_W-1:0] DIGIT_TWO = 4'd2;

  typedef logic [COLV_W-1:0] col_t;

  // One line store entry: codes of the same column two rows up and one row up
  typedef struct packed {
    logic [CODE_W-1:0] upper;
    logic [CODE_W-1:0] middle;
  } ls_entry_t;

  // Per-column status that a window cell reports to the decision logic
  typedef struct packed {
    logic two_up;
    logic two_mid;
    logic two_low;
    logic one_mid;
  } col_flags_t;

  // Column bits: [1:0] upper row, [3:2] middle row, [5:4] lower row
  function automatic col_flags_t col_flags(col_t c);
    col_flags_t f;
    f.two_up  = (c[1:0] == CODE_TWO);
    f.two_mid = (c[3:2] == CODE_TWO);
    f.two_low = (c[5:4] == CODE_TWO);
    f.one_mid = (c[3:2] == CODE_ONE);
    return f;
  endfunction

endpackage

// ===== rtl/gnmd_line_store.sv =====
// gnmd_line_store: the two line stores as one memory of upper/middle code
// pairs, with registered read, read-during-write forwarding and a clearing
// pass after reset. Depends on gnmd_pkg.
`timescale 1ns / 1ps

module gnmd_line_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [gnmd_pkg::COL_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [gnmd_pkg::COL_W-1:0] wr_addr,
  input  gnmd_pkg::ls_entry_t       wr_data,
  output gnmd_pkg::ls_entry_t       rd_data,
  output logic                      busy
);
  import gnmd_pkg::*;

  ls_entry_t        mem [MAX_COLS];
  ls_entry_t        rd_q_r;
  ls_entry_t        byp_data_r;
  logic             byp_r;
  logic             byp_nxt;
  logic             clr_busy_r;
  logic             clr_busy_nxt;
  logic [COL_W-1:0] clr_addr_r;
  logic [COL_W-1:0] clr_addr_nxt;
  logic             w_en;
  logic [COL_W-1:0] w_addr;
  ls_entry_t        w_data;

  // Clearing sweep, one entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == COL_W'(MAX_COLS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port: the sweep owns it while clearing
  always_comb begin
    w_en   = clr_busy_r | wr_en;
    w_addr = clr_busy_r ? clr_addr_r : wr_addr;
    w_data = clr_busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_addr] <= w_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // A read that meets a write to the same entry takes the new data
  assign byp_nxt = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;
  assign busy    = clr_busy_r;

endmodule

// ===== rtl/gnmd_cell.sv =====
// gnmd_cell: one column of the 3x3 window; takes its neighbor's column on
// each processed request and reports its code flags. Depends on gnmd_pkg.
`timescale 1ns / 1ps

module gnmd_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  gnmd_pkg::col_t         col_in,
  output gnmd_pkg::col_t         col_out,
  output gnmd_pkg::col_flags_t   flags
);
  import gnmd_pkg::*;

  col_t col_r;
  col_t col_nxt;

  // Load from the neighbor when the window moves
  assign col_nxt = shift_en ? col_in : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;
  assign flags   = col_flags(col_r);

endmodule

// ===== rtl/grid_neighbor_mark_detector.sv =====
// grid_neighbor_mark_detector: top level; size registers, scan counters,
// decision stage and output register. Depends on gnmd_pkg, gnmd_line_store
// and gnmd_cell.
`timescale 1ns / 1ps

// Grid cells stream in raster order, one request per clock while not stalled;
// request number p (grid cells and flush requests alike) decides the cell at
// raster position p - (col_count + 1), so col_count + 1 flush requests
// (in_tuser = 1) after the grid finish the last row. A cell of value 1 with a
// 2 anywhere in its edge-clipped 3x3 neighborhood is reported as its row and
// column; other requests give no result. A result passes through the decision
// stage register and the output register to out_*. The line store (one read
// and one write per cycle) and the two-column cell chain take a new request
// every cycle, so the sustained rate is one request per clock while out_* is
// not held by out_tready. After reset a clearing pass zeroes the line store,
// and in_tready stays low until it ends. Change row_count and col_count only
// while no request is in flight.

module grid_neighbor_mark_detector (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] cell_value, [7:4] zero
  input  logic        in_tuser,   // [0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] hit_row, [19:10] hit_col, [23:20] zero
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gnmd_pkg::*;

  // Size registers
  logic [CFG_W-1:0]     row_count_r, row_count_nxt;
  logic [CFG_W-1:0]     col_count_r, col_count_nxt;
  logic                 cfg_wr;
  logic                 cfg_sel;

  // Effective sizes
  logic [ROW_CMP_W-1:0] row_cnt_x;
  logic [ROW_CMP_W-1:0] rows;
  logic [COL_CMP_W-1:0] col_cnt_x;
  logic [COL_CMP_W-1:0] cols;

  // Scan counters
  logic [COL_W-1:0]     scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0]     scan_row_r, scan_row_nxt;
  logic [COL_CMP_W-1:0] ic_p1;
  logic                 in_accept;
  logic [CODE_W-1:0]    in_code;

  // Decision stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]     s1_ic_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [CODE_W-1:0]    s1_code_r;
  logic                 s1_fire;
  ls_entry_t            ls_rd;
  ls_entry_t            ls_wr;
  logic                 ls_busy;
  col_t                 new_col;
  col_t                 east_col;
  col_flags_t           east_f;
  col_flags_t           centre_f;
  col_flags_t           new_f;
  logic [ROW_CMP_W-1:0] srow;
  logic [COL_CMP_W-1:0] ic_x;
  logic                 ic_zero;
  logic                 a_ok, a_up, a_low, a_hit;
  logic                 b_ok, b_up, b_low, b_hit;
  logic                 hit;
  logic [HIT_W-1:0]     hit_row;
  logic [HIT_W-1:0]     hit_col;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [HIT_W-1:0]     out_row_r;
  logic [HIT_W-1:0]     out_col_r;

  // A 2 in one column, rows outside the grid masked
  function automatic logic col_two(col_flags_t f, logic up_ok, logic low_ok);
    return (up_ok & f.two_up) | f.two_mid | (low_ok & f.two_low);
  endfunction

  // ---------------------------------------------------------------- registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_paddr[REG_SEL_BIT];

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_ROW_COUNT: row_count_nxt = cfg_pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count_nxt = cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROW_COUNT: cfg_prdata = APB_DW'(row_count_r);
      REG_COL_COUNT: cfg_prdata = APB_DW'(col_count_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // Clamp the sizes; a column count of zero acts as one
  always_comb begin
    row_cnt_x = ROW_CMP_W'(row_count_r);
    rows      = (row_cnt_x > ROW_CMP_W'(MAX_ROWS)) ? ROW_CMP_W'(MAX_ROWS) : row_cnt_x;
    col_cnt_x = COL_CMP_W'(col_count_r);
    if (col_cnt_x == '0) begin
      cols = COL_CMP_W'(1);
    end else if (col_cnt_x > COL_CMP_W'(MAX_COLS)) begin
      cols = COL_CMP_W'(MAX_COLS);
    end else begin
      cols = col_cnt_x;
    end
  end

  // ------------------------------------------------------------ input side
  assign s1_fire   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~ls_busy & (~s1_valid_r | s1_fire);
  assign in_accept = in_tvalid & in_tready;

  // Flush requests and digits other than 1 and 2 enter as code 0
  always_comb begin
    in_code = CODE_OTHER;
    if (!in_tuser && (in_tdata[VALUE_W-1:0] inside {DIGIT_ONE, DIGIT_TWO})) begin
      in_code = in_tdata[CODE_W-1:0];
    end
  end

  // Raster position of the next request
  always_comb begin
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    ic_p1        = COL_CMP_W'(scan_col_r) + COL_CMP_W'(1);
    if (in_accept) begin
      if (ic_p1 >= cols) begin
        scan_col_nxt = '0;
        if (scan_row_r < ROW_W'(MAX_ROWS + 2)) begin
          scan_row_nxt = scan_row_r + 1'b1;
        end
      end else begin
        scan_col_nxt = COL_W'(ic_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else begin
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

  // Decision stage holds one request while its line store read completes
  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ic_r   <= scan_col_r;
      s1_row_r  <= scan_row_r;
      s1_code_r <= in_code;
    end
  end

  // ------------------------------------------------------------ line store
  // Each row moves down one store: middle becomes upper, the new code middle
  assign ls_wr.upper  = ls_rd.middle;
  assign ls_wr.middle = s1_code_r;

  gnmd_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (scan_col_r),
    .wr_en   (s1_fire),
    .wr_addr (s1_ic_r),
    .wr_data (ls_wr),
    .rd_data (ls_rd),
    .busy    (ls_busy)
  );

  // ------------------------------------------------------------ cell chain
  // New column enters the east cell, which hands its column to the centre
  // cell. The centre cell holds the leftmost window column; new_col is the rightmost.
  assign new_col = {s1_code_r, ls_rd.middle, ls_rd.upper};
  assign new_f   = col_flags(new_col);

  gnmd_cell u_cell_east (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .col_in   (new_col),
    .col_out  (east_col),
    .flags    (east_f)
  );

  gnmd_cell u_cell_centre (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .col_in   (east_col),
    .col_out  (),
    .flags    (centre_f)
  );

  // ------------------------------------------------------------ decision
  // Column 0: the last cell of the row before (east cell is its centre).
  // Other columns: the cell one column back (east cell again, after shift).
  always_comb begin
    srow    = ROW_CMP_W'(s1_row_r);
    ic_x    = COL_CMP_W'(s1_ic_r);
    ic_zero = (s1_ic_r == '0);

    a_ok  = (srow >= ROW_CMP_W'(2)) && ((srow - ROW_CMP_W'(2)) < rows);
    a_up  = (srow >= ROW_CMP_W'(3));
    a_low = ((srow - ROW_CMP_W'(1)) < rows);
    a_hit = a_ok && east_f.one_mid &&
            (col_two(east_f, a_up, a_low) ||
             ((cols >= COL_CMP_W'(2)) && col_two(centre_f, a_up, a_low)));

    b_ok  = (srow >= ROW_CMP_W'(1)) && ((srow - ROW_CMP_W'(1)) < rows) && (ic_x <= cols);
    b_up  = (srow >= ROW_CMP_W'(2));
    b_low = (srow < rows);
    b_hit = b_ok && east_f.one_mid &&
            (col_two(east_f, b_up, b_low) ||
             ((ic_x >= COL_CMP_W'(2)) && col_two(centre_f, b_up, b_low)) ||
             ((ic_x < cols) && col_two(new_f, b_up, b_low)));

    if (ic_zero) begin
      hit     = a_hit;
      hit_row = HIT_W'(srow - ROW_CMP_W'(2));
      hit_col = HIT_W'(cols - COL_CMP_W'(1));
    end else begin
      hit     = b_hit;
      hit_row = HIT_W'(srow - ROW_CMP_W'(1));
      hit_col = HIT_W'(ic_x - COL_CMP_W'(1));
    end
  end

  // ------------------------------------------------------------ output
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && hit) begin
      out_row_r <= hit_row;
      out_col_r <= hit_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_col_r, out_row_r});

  // ------------------------------------------------------------ assertions
  // No request is taken while the line store is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ls_busy |-> !in_tready)
    else $error("request accepted during line store clear");

  // The decision stage is empty for the whole clearing pass
  a_s1_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ls_busy |-> !s1_valid_r)
    else $error("decision stage busy during line store clear");

  // A stalled decision stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=>
      (s1_valid_r && $stable(s1_ic_r) && $stable(s1_row_r) && $stable(s1_code_r)))
    else $error("decision stage lost its request while stalled");

  // The window only moves when a request leaves the decision stage
  a_window_move: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(east_col))
    else $error("window moved without a request");

endmodule
